### hdl/gtmna_pkg.sv
package gtmna_pkg;

    localparam int HELD_DEPTH  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_CONTROLS = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;

    localparam logic [1:0] EV_NOTE_OFF = 2'd0;
    localparam logic [1:0] EV_NOTE_ON  = 2'd1;
    localparam logic [1:0] EV_CONTROL  = 2'd2;

    localparam logic [2:0] REG_LEGATO    = 3'd0;
    localparam logic [2:0] REG_CHANNEL   = 3'd1;
    localparam logic [2:0] REG_X_ENABLE  = 3'd2;
    localparam logic [2:0] REG_X_NUMBER  = 3'd3;
    localparam logic [2:0] REG_Y_ENABLE  = 3'd4;
    localparam logic [2:0] REG_Y_NUMBER  = 3'd5;

    // held-list entry, channel in the upper bits
    typedef struct packed {
        logic [3:0] chan_m1;
        logic [6:0] pitch;
    } entry_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] chan_m1;
        logic [6:0] d1;
        logic [6:0] d2;
    } slot_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic       legato;
        logic [6:0] pitch;
        logic [6:0] vel;
        logic [3:0] chan_m1;
        logic       x_en;
        logic [6:0] x_num;
        logic [6:0] x_val;
        logic       y_en;
        logic [6:0] y_num;
        logic [6:0] y_val;
    } req_t;

endpackage

### hdl/gtmna_front.sv
module gtmna_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       operation,
    input  logic [6:0]       note,
    input  logic [6:0]       velocity,
    input  logic [15:0]      x_position,
    input  logic [15:0]      y_position,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [6:0]       cfg_data,
    input  logic             queue_full,
    output logic             push,
    output gtmna_pkg::req_t  push_req
);
    import gtmna_pkg::*;

    logic       legato_reg;
    logic [4:0] channel_reg;
    logic       x_en_reg;
    logic [6:0] x_num_reg;
    logic       y_en_reg;
    logic [6:0] y_num_reg;
    logic [3:0] chan_m1;

    // round(pos * 127 / 32768), saturated at 127
    function automatic logic [6:0] cc_scale(input logic [15:0] pos);
        logic [22:0] prod;
        prod = {pos, 7'd0} - {7'd0, pos} + 23'd16384;
        return (prod[22:15] > 8'd127) ? 7'd127 : prod[21:15];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            legato_reg  <= 1'b0;
            channel_reg <= 5'd1;
            x_en_reg    <= 1'b0;
            x_num_reg   <= 7'd1;
            y_en_reg    <= 1'b0;
            y_num_reg   <= 7'd2;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEGATO:   legato_reg  <= cfg_data[0];
                REG_CHANNEL:  channel_reg <= cfg_data[4:0];
                REG_X_ENABLE: x_en_reg    <= cfg_data[0];
                REG_X_NUMBER: x_num_reg   <= cfg_data;
                REG_Y_ENABLE: y_en_reg    <= cfg_data[0];
                REG_Y_NUMBER: y_num_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        if (channel_reg == 5'd0)
            chan_m1 = 4'd0;
        else if (channel_reg > 5'd16)
            chan_m1 = 4'd15;
        else
            chan_m1 = 4'(channel_reg - 5'd1);
    end

    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        push_req.op      = operation;
        push_req.legato  = legato_reg;
        push_req.pitch   = note;
        push_req.vel     = (velocity == 7'd0) ? 7'd1 : velocity;
        push_req.chan_m1 = chan_m1;
        push_req.x_en    = x_en_reg;
        push_req.x_num   = x_num_reg;
        push_req.x_val   = cc_scale(x_position);
        push_req.y_en    = y_en_reg;
        push_req.y_num   = y_num_reg;
        push_req.y_val   = cc_scale(y_position);
    end

endmodule

### hdl/gtmna_queue.sv
module gtmna_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gtmna_pkg::req_t  push_req,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop,
    output gtmna_pkg::req_t  pop_req
);
    import gtmna_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

    req_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_req   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_ONE;
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_ONE;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_ONE;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_req;
    end

endmodule

### hdl/gtmna_back.sv
module gtmna_back #(
    parameter int MAX_HELD = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  gtmna_pkg::req_t  req,
    output logic             req_pop,
    output logic             event_strobe,
    output logic [1:0]       event_kind,
    output logic [4:0]       event_channel,
    output logic [6:0]       first_data,
    output logic [6:0]       second_data,
    output logic             last_event
);
    import gtmna_pkg::*;

    localparam int HELD_CAP = (MAX_HELD < HELD_DEPTH) ? MAX_HELD : HELD_DEPTH;
    localparam int CNT_W    = $clog2(HELD_CAP + 1);
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(HELD_CAP);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    localparam int NUM_SLOTS = 4;
    localparam int SLOT_A    = 0;
    localparam int SLOT_B    = 1;
    localparam int SLOT_X    = 2;
    localparam int SLOT_Y    = 3;
    localparam logic [NUM_SLOTS-1:0] SLOT_ONE = NUM_SLOTS'(1);

    entry_t               held_reg  [HELD_CAP];
    entry_t               held_next [HELD_CAP];
    entry_t               held_up   [HELD_CAP];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 snd_valid_reg;
    logic                 snd_valid_next;
    logic [6:0]           snd_pitch_reg;
    logic [6:0]           snd_pitch_next;
    logic [3:0]           snd_chan_reg;
    logic [3:0]           snd_chan_next;
    slot_t                slot_reg  [NUM_SLOTS];
    slot_t                slot_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] pend_reg;
    logic [NUM_SLOTS-1:0] pend_next;
    logic                 rel_reg;
    logic                 rel_next;
    logic                 strobe_reg;
    logic                 strobe_next;
    slot_t                out_reg;
    slot_t                out_next;
    logic                 last_reg;
    logic                 last_next;

    entry_t               new_entry;
    logic [HELD_CAP-1:0]  hit;
    logic [HELD_CAP-1:0]  at_or_after;
    logic                 found;
    logic [NUM_SLOTS-1:0] low_bit;
    logic [1:0]           sel;
    logic                 same_note;

    assign new_entry = {req.chan_m1, req.pitch};
    assign req_pop   = req_valid && (pend_reg == '0) && !rel_reg;
    assign same_note = snd_valid_reg && (snd_pitch_reg == req.pitch)
                       && (snd_chan_reg == req.chan_m1);

    generate
        for (genvar g = 0; g < HELD_CAP; g++)
        begin : g_up
            if (g < HELD_CAP - 1)
            begin : g_shift
                assign held_up[g] = held_reg[g + 1];
            end
            else
            begin : g_top
                assign held_up[g] = held_reg[g];
            end
        end
    endgenerate

    // match search; entries from the hit onward move down on a retrigger
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int j = 0; j < HELD_CAP; j++)
        begin
            hit[j] = (CNT_W'(j) < count_reg) && (held_reg[j] == new_entry);
            seen = seen | hit[j];
            at_or_after[j] = seen;
        end
        found = seen;
    end

    always_comb
    begin
        sel = 2'(SLOT_Y);
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
                sel = 2'(k);
        end
        low_bit = pend_reg & (~pend_reg + SLOT_ONE);
    end

    always_comb
    begin
        for (int j = 0; j < HELD_CAP; j++)
            held_next[j] = held_reg[j];
        for (int k = 0; k < NUM_SLOTS; k++)
            slot_next[k] = slot_reg[k];
        count_next     = count_reg;
        snd_valid_next = snd_valid_reg;
        snd_pitch_next = snd_pitch_reg;
        snd_chan_next  = snd_chan_reg;
        pend_next      = pend_reg;
        rel_next       = rel_reg;
        strobe_next    = 1'b0;
        out_next       = out_reg;
        last_next      = 1'b0;

        if (pend_reg != '0)
        begin
            strobe_next = 1'b1;
            out_next    = slot_reg[sel];
            pend_next   = pend_reg & ~low_bit;
            last_next   = (pend_next == '0);
        end
        else if (rel_reg)
        begin
            strobe_next = 1'b1;
            out_next    = '{kind: EV_NOTE_OFF, chan_m1: held_reg[0].chan_m1,
                            d1: held_reg[0].pitch, d2: 7'd0};
            for (int j = 0; j < HELD_CAP; j++)
                held_next[j] = held_up[j];
            count_next = count_reg - CNT_ONE;
            last_next  = (count_reg == CNT_ONE);
            rel_next   = (count_reg != CNT_ONE);
        end
        else if (req_pop)
        begin
            slot_next[SLOT_X] = '{kind: EV_CONTROL, chan_m1: req.chan_m1,
                                  d1: req.x_num, d2: req.x_val};
            slot_next[SLOT_Y] = '{kind: EV_CONTROL, chan_m1: req.chan_m1,
                                  d1: req.y_num, d2: req.y_val};
            case (req.op)
                OP_NOTE_ON:
                begin
                    pend_next[SLOT_X] = req.x_en;
                    pend_next[SLOT_Y] = req.y_en;
                    if (req.legato)
                    begin
                        snd_valid_next = 1'b1;
                        snd_pitch_next = req.pitch;
                        snd_chan_next  = req.chan_m1;
                        if (found)
                        begin
                            slot_next[SLOT_A] = '{kind: EV_NOTE_OFF, chan_m1: req.chan_m1,
                                                  d1: req.pitch, d2: 7'd0};
                            slot_next[SLOT_B] = '{kind: EV_NOTE_ON, chan_m1: req.chan_m1,
                                                  d1: req.pitch, d2: req.vel};
                            pend_next[SLOT_A] = 1'b1;
                            pend_next[SLOT_B] = 1'b1;
                            for (int j = 0; j < HELD_CAP; j++)
                            begin
                                if (at_or_after[j] && (CNT_W'(j) + CNT_ONE < count_reg))
                                    held_next[j] = held_up[j];
                                else if (at_or_after[j]
                                         && (CNT_W'(j) + CNT_ONE == count_reg))
                                    held_next[j] = new_entry;
                            end
                        end
                        else
                        begin
                            slot_next[SLOT_A] = '{kind: EV_NOTE_ON, chan_m1: req.chan_m1,
                                                  d1: req.pitch, d2: req.vel};
                            pend_next[SLOT_A] = 1'b1;
                            if (count_reg >= CAP_COUNT)
                            begin
                                // list full: evict the oldest note
                                slot_next[SLOT_B] = '{kind: EV_NOTE_OFF,
                                                      chan_m1: held_reg[0].chan_m1,
                                                      d1: held_reg[0].pitch, d2: 7'd0};
                                pend_next[SLOT_B] = 1'b1;
                                for (int j = 0; j < HELD_CAP; j++)
                                begin
                                    if (j == HELD_CAP - 1)
                                        held_next[j] = new_entry;
                                    else
                                        held_next[j] = held_up[j];
                                end
                            end
                            else
                            begin
                                for (int j = 0; j < HELD_CAP; j++)
                                begin
                                    if (CNT_W'(j) == count_reg)
                                        held_next[j] = new_entry;
                                end
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                    end
                    else if (!same_note)
                    begin
                        slot_next[SLOT_A] = '{kind: EV_NOTE_OFF, chan_m1: snd_chan_reg,
                                              d1: snd_pitch_reg, d2: 7'd0};
                        slot_next[SLOT_B] = '{kind: EV_NOTE_ON, chan_m1: req.chan_m1,
                                              d1: req.pitch, d2: req.vel};
                        pend_next[SLOT_A] = snd_valid_reg;
                        pend_next[SLOT_B] = 1'b1;
                        snd_valid_next    = 1'b1;
                        snd_pitch_next    = req.pitch;
                        snd_chan_next     = req.chan_m1;
                    end
                end
                OP_CONTROLS:
                begin
                    pend_next[SLOT_X] = req.x_en;
                    pend_next[SLOT_Y] = req.y_en;
                end
                OP_RELEASE:
                begin
                    if (req.legato || (count_reg != '0))
                    begin
                        snd_valid_next = 1'b0;
                        rel_next       = (count_reg != '0);
                    end
                    else
                    begin
                        slot_next[SLOT_A] = '{kind: EV_NOTE_OFF, chan_m1: snd_chan_reg,
                                              d1: snd_pitch_reg, d2: 7'd0};
                        pend_next[SLOT_A] = snd_valid_reg;
                        snd_valid_next    = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            snd_valid_reg <= 1'b0;
            snd_pitch_reg <= 7'd0;
            snd_chan_reg  <= 4'd0;
            pend_reg      <= '0;
            rel_reg       <= 1'b0;
            strobe_reg    <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            snd_valid_reg <= snd_valid_next;
            snd_pitch_reg <= snd_pitch_next;
            snd_chan_reg  <= snd_chan_next;
            pend_reg      <= pend_next;
            rel_reg       <= rel_next;
            strobe_reg    <= strobe_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < HELD_CAP; j++)
            held_reg[j] <= held_next[j];
        for (int k = 0; k < NUM_SLOTS; k++)
            slot_reg[k] <= slot_next[k];
        out_reg <= out_next;
    end

    assign event_strobe  = strobe_reg;
    assign event_kind    = out_reg.kind;
    assign event_channel = {1'b0, out_reg.chan_m1} + 5'd1;
    assign first_data    = out_reg.d1;
    assign second_data   = out_reg.d2;
    assign last_event    = last_reg;

endmodule

### hdl/gesture_to_midi_note_allocator.sv
// Gesture to MIDI note allocator.
// Request channel: a gesture request is taken on a clock edge with start high
// and busy low. operation selects note on with controls, controls only or
// release; note, velocity and the Q1.15 X/Y positions ride along.
// Config port: cfg_write with cfg_index and cfg_data writes one register
// (legato, channel, X/Y CC enables and numbers); write only while idle.
// Event channel: each MIDI event shows for one cycle with event_strobe high;
// last_event marks the final event of a request. The receiver cannot stall.
// Timing: the front classifies and scales the CC values into a two-entry
// queue; the back pops one request, plans it into its pending slots and then
// emits one event per cycle, popping no new request until all are out. A
// request makes 0 to 4 events, or up to MAX_HELD notes for a release, capped
// at 16. A taken request goes to the queue, then to the back's slot registers,
// then to its output register. busy rises while the queue is full.
// Reset: config returns to mono mode, channel 1, CCs off (numbers 1 and 2);
// the held list is empty and no note sounds. Held entries need no clearing.
module gesture_to_midi_note_allocator #(
    parameter int MAX_HELD = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [6:0]  note,
    input  logic [6:0]  velocity,
    input  logic [15:0] x_position,
    input  logic [15:0] y_position,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        event_strobe,
    output logic [1:0]  event_kind,
    output logic [4:0]  event_channel,
    output logic [6:0]  first_data,
    output logic [6:0]  second_data,
    output logic        last_event
);
    import gtmna_pkg::*;

    logic queue_full;
    logic push;
    req_t push_req;
    logic pop_valid;
    logic pop;
    req_t pop_req;

    gtmna_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .note       (note),
        .velocity   (velocity),
        .x_position (x_position),
        .y_position (y_position),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_req   (push_req)
    );

    gtmna_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_req   (pop_req)
    );

    gtmna_back #(
        .MAX_HELD (MAX_HELD)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (pop_valid),
        .req           (pop_req),
        .req_pop       (pop),
        .event_strobe  (event_strobe),
        .event_kind    (event_kind),
        .event_channel (event_channel),
        .first_data    (first_data),
        .second_data   (second_data),
        .last_event    (last_event)
    );

endmodule

### dv/testbench.sv
module testbench;
    import gtmna_pkg::*;

    localparam logic [1:0] OP_IGNORED   = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int END_WAIT      = 4000;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 26;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] chan;
        logic [6:0] d1;
        logic [6:0] d2;
        logic       last;
    } midi_ev_t;

    typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t     kind;
        logic [1:0]     op;
        logic [6:0]     pitch;
        logic [6:0]     vel;
        logic [15:0]    xpos;
        logic [15:0]    ypos;
        logic [2:0]     reg_idx;
        logic [6:0]     reg_val;
        int             n_fixed;
        midi_ev_t [1:0] fixed;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] x_position;
    logic [15:0] y_position;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        event_strobe;
    logic [1:0]  event_kind;
    logic [4:0]  event_channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic        last_event;

    gesture_to_midi_note_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .note         (note),
        .velocity     (velocity),
        .x_position   (x_position),
        .y_position   (y_position),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .event_strobe (event_strobe),
        .event_kind   (event_kind),
        .event_channel(event_channel),
        .first_data   (first_data),
        .second_data  (second_data),
        .last_event   (last_event)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // allocator model state
    entry_t     held_notes [HELD_DEPTH];
    int         held_cnt = 0;
    logic       snd_valid = 1'b0;
    logic [6:0] snd_pitch = '0;
    logic [3:0] snd_chan_m1 = '0;
    logic       cfg_legato = 1'b0;
    logic [4:0] cfg_chan = 5'd1;
    logic       cfg_x_en = 1'b0;
    logic [6:0] cfg_x_num = 7'd1;
    logic       cfg_y_en = 1'b0;
    logic [6:0] cfg_y_num = 7'd2;

    midi_ev_t   plan_q [$];
    midi_ev_t   due_q [$];
    step_t      script [$];
    int         mismatch_cnt = 0;
    int         cycle_cnt = 0;
    int         idle_pct = 10;

    function automatic midi_ev_t mk_ev(logic [1:0] kind, logic [4:0] chan, logic [6:0] d1,
                                       logic [6:0] d2, logic last);
        midi_ev_t ev;
        ev.kind = kind;
        ev.chan = chan;
        ev.d1   = d1;
        ev.d2   = d2;
        ev.last = last;
        return ev;
    endfunction

    function automatic void emit(logic [1:0] kind, logic [4:0] chan, logic [6:0] d1,
                                 logic [6:0] d2);
        if (plan_q.size() < 16)
            plan_q = {plan_q, mk_ev(kind, chan, d1, d2, 1'b0)};
    endfunction

    function automatic logic [6:0] cc_value(logic [15:0] pos);
        logic [31:0] v;
        v = (32'(pos) * 32'd127 + 32'd16384) >> 15;
        return (v > 32'd127) ? 7'd127 : v[6:0];
    endfunction

    function automatic void sounding_off();
        if (snd_valid)
        begin
            emit(EV_NOTE_OFF, {1'b0, snd_chan_m1} + 5'd1, snd_pitch, 7'd0);
            snd_valid = 1'b0;
        end
    endfunction

    function automatic void release_held();
        for (int i = 0; i < held_cnt; i++)
            emit(EV_NOTE_OFF, {1'b0, held_notes[i].chan_m1} + 5'd1, held_notes[i].pitch, 7'd0);
        held_cnt = 0;
        snd_valid = 1'b0;
    endfunction

    function automatic void strike_note(logic [6:0] pitch, logic [6:0] vel, logic [4:0] ch);
        logic [3:0] cm1;
        entry_t     ent;
        int         hit;
        cm1 = 4'(ch - 5'd1);
        ent.chan_m1 = cm1;
        ent.pitch = pitch;
        if (cfg_legato)
        begin
            hit = -1;
            for (int i = 0; i < held_cnt; i++)
                if (hit < 0 && held_notes[i] == ent)
                    hit = i;
            if (hit >= 0)
            begin
                emit(EV_NOTE_OFF, ch, pitch, 7'd0);
                emit(EV_NOTE_ON, ch, pitch, vel);
                for (int i = hit; i < held_cnt - 1; i++)
                    held_notes[i] = held_notes[i + 1];
                held_notes[held_cnt - 1] = ent;
            end
            else
            begin
                emit(EV_NOTE_ON, ch, pitch, vel);
                if (held_cnt >= HELD_DEPTH)
                begin
                    emit(EV_NOTE_OFF, {1'b0, held_notes[0].chan_m1} + 5'd1,
                         held_notes[0].pitch, 7'd0);
                    for (int i = 0; i < HELD_DEPTH - 1; i++)
                        held_notes[i] = held_notes[i + 1];
                    held_cnt = HELD_DEPTH - 1;
                end
                held_notes[held_cnt] = ent;
                held_cnt++;
            end
        end
        else
        begin
            if (snd_valid && snd_pitch == pitch && snd_chan_m1 == cm1)
                return;
            sounding_off();
            emit(EV_NOTE_ON, ch, pitch, vel);
        end
        snd_valid = 1'b1;
        snd_pitch = pitch;
        snd_chan_m1 = cm1;
    endfunction

    function automatic void add_controls(logic [4:0] ch, logic [15:0] xp, logic [15:0] yp);
        if (cfg_x_en)
            emit(EV_CONTROL, ch, cfg_x_num, cc_value(xp));
        if (cfg_y_en)
            emit(EV_CONTROL, ch, cfg_y_num, cc_value(yp));
    endfunction

    // fills plan_q with the MIDI events one gesture causes
    function automatic void plan_midi_events(logic [1:0] op, logic [6:0] pitch, logic [6:0] vel,
                                             logic [15:0] xp, logic [15:0] yp);
        logic [4:0] ch;
        logic [6:0] v;
        midi_ev_t   tail;
        plan_q.delete();
        ch = cfg_chan;
        if (ch == 5'd0)
            ch = 5'd1;
        if (ch > 5'd16)
            ch = 5'd16;
        v = (vel == 7'd0) ? 7'd1 : vel;
        case (op)
            OP_NOTE_ON:
            begin
                strike_note(pitch, v, ch);
                add_controls(ch, xp, yp);
            end
            OP_CONTROLS:
                add_controls(ch, xp, yp);
            OP_RELEASE:
            begin
                if (cfg_legato || held_cnt > 0)
                    release_held();
                else
                    sounding_off();
            end
            default: ;
        endcase
        if (plan_q.size() != 0)
        begin
            tail = plan_q.pop_back();
            tail.last = 1'b1;
            plan_q = {plan_q, tail};
        end
    endfunction

    function automatic void add_req(logic [1:0] op, logic [6:0] pitch, logic [6:0] vel,
                                    logic [15:0] xp, logic [15:0] yp, int n_fixed = -1,
                                    midi_ev_t ev0 = '0, midi_ev_t ev1 = '0);
        step_t s;
        s.kind = STEP_REQ;
        s.op = op;
        s.pitch = pitch;
        s.vel = vel;
        s.xpos = xp;
        s.ypos = yp;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.n_fixed = n_fixed;
        s.fixed[0] = ev0;
        s.fixed[1] = ev1;
        script = {script, s};
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [6:0] val);
        step_t s;
        s.kind = STEP_CFG;
        s.op = OP_NOTE_ON;
        s.pitch = '0;
        s.vel = '0;
        s.xpos = '0;
        s.ypos = '0;
        s.reg_idx = idx;
        s.reg_val = val;
        s.n_fixed = -1;
        s.fixed = '0;
        script = {script, s};
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        midi_ev_t got;
        midi_ev_t want;
        if (rst_n && event_strobe)
        begin
            got = mk_ev(event_kind, event_channel, first_data, second_data, last_event);
            if (due_q.size() == 0)
                note_mismatch($sformatf(
                    "unexpected event kind=%0d ch=%0d d1=%0d d2=%0d last=%0d",
                    got.kind, got.chan, got.d1, got.d2, got.last));
            else
            begin
                want = due_q.pop_front();
                if (want.kind !== got.kind || want.chan !== got.chan || want.d1 !== got.d1 ||
                    want.d2 !== got.d2 || want.last !== got.last)
                    note_mismatch($sformatf({
                        "event mismatch: exp kind=%0d ch=%0d d1=%0d d2=%0d last=%0d, ",
                        "got kind=%0d ch=%0d d1=%0d d2=%0d last=%0d"},
                        want.kind, want.chan, want.d1, want.d2, want.last,
                        got.kind, got.chan, got.d1, got.d2, got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge after the request is taken
    task automatic issue_gesture(logic [1:0] op, logic [6:0] pitch, logic [6:0] vel,
                                 logic [15:0] xp, logic [15:0] yp, int n_fixed,
                                 midi_ev_t [1:0] fixed);
        start = 1'b1;
        operation = op;
        note = pitch;
        velocity = vel;
        x_position = xp;
        y_position = yp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        plan_midi_events(op, pitch, vel, xp, yp);
        if (n_fixed < 0)
        begin
            foreach (plan_q[i])
                due_q = {due_q, plan_q[i]};
        end
        else
        begin
            for (int i = 0; i < n_fixed; i++)
                due_q = {due_q, fixed[i]};
        end
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic hold_until_drained();
        start = 1'b0;
        while (due_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_LEGATO:   cfg_legato = val[0];
            REG_CHANNEL:  cfg_chan = val[4:0];
            REG_X_ENABLE: cfg_x_en = val[0];
            REG_X_NUMBER: cfg_x_num = val;
            REG_Y_ENABLE: cfg_y_en = val[0];
            REG_Y_NUMBER: cfg_y_num = val;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_position();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(0, 32768));
            3: return 16'($urandom);
            default: return 16'($urandom_range(32760, 32775));
        endcase
    endfunction

    task automatic run_phase(int n_items, bit legato_mode, bit drain_mid);
        logic [6:0] ch;
        logic [1:0] op;
        logic [6:0] pitch;
        int         r;
        settle();
        case ($urandom_range(0, 5))
            0: ch = 7'd0;
            1: ch = 7'd1;
            2: ch = 7'd16;
            3: ch = 7'd31;
            default: ch = 7'($urandom_range(0, 31));
        endcase
        write_reg(REG_LEGATO, 7'(legato_mode));
        write_reg(REG_CHANNEL, ch);
        write_reg(REG_X_ENABLE, 7'($urandom_range(0, 1)));
        write_reg(REG_X_NUMBER, 7'($urandom_range(0, 127)));
        write_reg(REG_Y_ENABLE, 7'($urandom_range(0, 1)));
        write_reg(REG_Y_NUMBER, 7'($urandom_range(0, 127)));
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_IGNORED;
            else if (r < (legato_mode ? 6 : 18))
                op = OP_RELEASE;
            else if (r < (legato_mode ? 18 : 32))
                op = OP_CONTROLS;
            else
                op = OP_NOTE_ON;
            // small note pools so that repeats and a full held list happen often
            if ($urandom_range(0, 9) == 0)
                pitch = 7'($urandom_range(0, 127));
            else if (legato_mode)
                pitch = 7'(40 + $urandom_range(0, 23));
            else
                pitch = 7'(60 + $urandom_range(0, 5));
            issue_gesture(op, pitch, 7'($urandom_range(0, 127)), pick_position(),
                          pick_position(), -1, '0);
            if (drain_mid && i == n_items / 2)
                hold_until_drained();
        end
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_NOTE_ON;
        note = '0;
        velocity = '0;
        x_position = '0;
        y_position = '0;
        cfg_write = 1'b0;
        cfg_index = REG_LEGATO;
        cfg_data = '0;
        foreach (held_notes[i])
            held_notes[i] = '0;

        // mono mode, channel 1, controls off
        add_req(OP_NOTE_ON, 7'd0, 7'd0, 16'd0, 16'd0, 1,
                mk_ev(EV_NOTE_ON, 5'd1, 7'd0, 7'd1, 1'b1));
        add_req(OP_NOTE_ON, 7'd0, 7'd5, 16'd0, 16'd0, 0);
        add_req(OP_NOTE_ON, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 2,
                mk_ev(EV_NOTE_OFF, 5'd1, 7'd0, 7'd0, 1'b0),
                mk_ev(EV_NOTE_ON, 5'd1, 7'd127, 7'd127, 1'b1));
        add_req(OP_RELEASE, 7'd127, 7'd127, 16'd0, 16'd0, 1,
                mk_ev(EV_NOTE_OFF, 5'd1, 7'd127, 7'd0, 1'b1));
        add_req(OP_RELEASE, 7'd0, 7'd0, 16'd0, 16'd0, 0);
        add_req(OP_IGNORED, 7'd5, 7'd5, 16'd100, 16'd100, 0);
        add_cfg(REG_X_ENABLE, 7'd1);
        add_cfg(REG_X_NUMBER, 7'd127);
        add_cfg(REG_Y_ENABLE, 7'd1);
        add_cfg(REG_Y_NUMBER, 7'd0);
        add_req(OP_CONTROLS, 7'd0, 7'd0, 16'd0, 16'd32768, 2,
                mk_ev(EV_CONTROL, 5'd1, 7'd127, 7'd0, 1'b0),
                mk_ev(EV_CONTROL, 5'd1, 7'd0, 7'd127, 1'b1));
        add_req(OP_CONTROLS, 7'd0, 7'd0, 16'hFFFF, 16'd129);
        add_req(OP_CONTROLS, 7'd0, 7'd0, 16'd130, 16'd16384);
        // channel 0 acts as 1, anything above 16 as 16
        add_cfg(REG_CHANNEL, 7'd0);
        add_req(OP_NOTE_ON, 7'd60, 7'd64, 16'd32767, 16'd32769);
        add_cfg(REG_CHANNEL, 7'd16);
        add_req(OP_NOTE_ON, 7'd60, 7'd64, 16'd258, 16'd257);
        add_cfg(REG_CHANNEL, 7'd31);
        add_req(OP_NOTE_ON, 7'd60, 7'd1, 16'd1, 16'd32768);
        // held-note list: repeat on one channel, same pitch on another
        add_cfg(REG_X_ENABLE, 7'd0);
        add_cfg(REG_Y_ENABLE, 7'd0);
        add_cfg(REG_LEGATO, 7'd1);
        add_cfg(REG_CHANNEL, 7'd2);
        add_req(OP_NOTE_ON, 7'd10, 7'd90, 16'd0, 16'd0);
        add_req(OP_NOTE_ON, 7'd20, 7'd91, 16'd0, 16'd0);
        add_req(OP_NOTE_ON, 7'd10, 7'd92, 16'd0, 16'd0);
        add_cfg(REG_CHANNEL, 7'd3);
        add_req(OP_NOTE_ON, 7'd10, 7'd93, 16'd0, 16'd0);
        // mono with a non-empty held list: note on leaves it, release empties it
        add_cfg(REG_LEGATO, 7'd0);
        add_req(OP_NOTE_ON, 7'd30, 7'd94, 16'd0, 16'd0);
        add_req(OP_RELEASE, 7'd0, 7'd0, 16'd0, 16'd0);
        add_req(OP_RELEASE, 7'd0, 7'd0, 16'd0, 16'd0);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == STEP_CFG)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                issue_gesture(script[i].op, script[i].pitch, script[i].vel, script[i].xpos,
                              script[i].ypos, script[i].n_fixed, script[i].fixed);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = (p == 2) ? 0 : 10;
            run_phase(PHASE_ITEMS, (p % 2 == 1) || ($urandom_range(0, 3) == 0), p == 4);
        end

        start = 1'b0;
        guard = 0;
        while (due_q.size() != 0 && guard < END_WAIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (due_q.size() != 0)
            note_mismatch($sformatf("%0d expected events never arrived", due_q.size()));

        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
